### hdl/rtb_pkg.sv
// Shared constants, codes and record types of the rule trie builder.
package rtb_pkg;

   // Store sizes. Every index field of the interface is IDX_W bits wide.
   localparam int NODE_SLOTS = 1024;
   localparam int EDGE_SLOTS = 1024;
   localparam int RULE_SLOTS = 1024;
   localparam int TOKEN_BITS = 16;

   // Fixed widths of the interface fields.
   localparam int IDX_W    = 10;
   localparam int TOKEN_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int ASSOC_W  = 2;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // The node/rule table holds both regions, selected by the top address bit.
   localparam int TAB_AW = IDX_W + 1;
   localparam logic REGION_NODE = 1'b0;
   localparam logic REGION_RULE = 1'b1;

   localparam logic [IDX_W-1:0] ROOT_NODE = IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_NEW_RULE  = 2'd0,
      OP_ADD_TOKEN = 2'd1,
      OP_END_RULE  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_MARKED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_NODE_RD,
      S_NODE_CHK,
      S_EDGE_CHK,
      S_ALLOC,
      S_ALLOC_RULE,
      S_MARK_CHK,
      S_EMIT
   } state_type;

   // One word of the node/rule table. A node uses ptr as its first edge and
   // mark as its rule mark; a rule uses ptr as its cursor and tok as its
   // result token.
   typedef struct packed {
      logic [TOKEN_BITS-1:0] tok;
      logic [IDX_W-1:0]      ptr;
      logic [IDX_W-1:0]      mark;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0]      next;
      logic [TOKEN_BITS-1:0] tok;
      logic [IDX_W-1:0]      target;
      logic [PRIO_W-1:0]     prio;
      logic [ASSOC_W-1:0]    assoc;
   } edge_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   rule_index;
      logic [TOKEN_W-1:0] token_code;
      logic [PRIO_W-1:0]  priority_level;
      logic [ASSOC_W-1:0] assoc_mode;
      logic [IDX_W-1:0]   node_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic             matched_existing;
      status_type       status;
   } rsp_type;

endpackage

### hdl/rule_trie_builder_core.sv
// Top level of the rule trie builder: control sequencer and trie memories.
//
//  Channel  Direction  Handshake            Beat contents
//  req_     in         req_valid/req_ready  op, rule, token, priority, assoc, node
//  rsp_     out        rsp_valid/rsp_ready  result index, matched flag, status
//
// new_rule and an unused op go straight to S_EMIT; end_rule passes S_MARK_CHK;
// add_token passes S_NODE_RD, S_NODE_CHK and S_EDGE_CHK for each edge up to a
// match, or S_ALLOC and S_ALLOC_RULE when a node is allocated: one edge memory read per edge.
// After reset a clearing pass writes all 2048 words of the node/rule table,
// and the first request is taken only when that pass is over.
// A result waits in an output register; the next request is taken meanwhile
// and only its own result stalls while rsp_ready is low.
module rule_trie_builder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rtb_pkg::OP_W-1:0]       req_op,
   input  logic [rtb_pkg::IDX_W-1:0]      req_rule_index,
   input  logic [rtb_pkg::TOKEN_W-1:0]    req_token_code,
   input  logic [rtb_pkg::PRIO_W-1:0]     req_priority_level,
   input  logic [rtb_pkg::ASSOC_W-1:0]    req_assoc_mode,
   input  logic [rtb_pkg::IDX_W-1:0]      req_node_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rtb_pkg::IDX_W-1:0]      rsp_result_index,
   output logic                           rsp_matched_existing,
   output logic [rtb_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int IDX_W  = rtb_pkg::IDX_W;
   localparam int TAB_AW = rtb_pkg::TAB_AW;

   // Control state.
   rtb_pkg::state_type state_ff, state_in;
   logic [TAB_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]   node_count_ff, node_count_in;
   logic [IDX_W-1:0]   edge_count_ff, edge_count_in;
   logic [IDX_W-1:0]   rule_count_ff, rule_count_in;

   // Working registers of the item in flight.
   rtb_pkg::req_type   req_ff, req_in;
   rtb_pkg::entry_type rule_word_ff, rule_word_in;
   rtb_pkg::entry_type node_word_ff, node_word_in;
   rtb_pkg::rsp_type   res_ff, res_in;

   // Node/rule table port.
   rtb_pkg::entry_type tab_mem [2**TAB_AW];
   rtb_pkg::entry_type tab_rdata_ff;
   rtb_pkg::entry_type tab_wdata;
   logic [TAB_AW-1:0]  tab_raddr;
   logic [TAB_AW-1:0]  tab_waddr;
   logic               tab_we;

   // Edge table port.
   rtb_pkg::edge_entry_type edge_mem [rtb_pkg::EDGE_SLOTS];
   rtb_pkg::edge_entry_type edge_rdata_ff;
   rtb_pkg::edge_entry_type edge_wdata;
   logic [IDX_W-1:0]        edge_raddr;
   logic [IDX_W-1:0]        edge_waddr;
   logic                    edge_we;

   // Helpers.
   rtb_pkg::req_type   req_beat;
   rtb_pkg::op_type    req_op_code;
   logic               accept;
   logic               rule_full;
   logic               grow_full;
   logic               rule_oor;
   logic               node_oor;
   logic               token_hit;
   logic [IDX_W:0]     rule_next_w;
   logic [IDX_W:0]     node_next_w;
   logic [IDX_W:0]     edge_next_w;
   logic               rsp_push;
   logic               slot_free;
   rtb_pkg::rsp_type   rsp_data;

   assign req_ready   = (state_ff == rtb_pkg::S_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_op_code = rtb_pkg::op_type'(req_op);

   assign req_beat.op             = req_op;
   assign req_beat.rule_index     = req_rule_index;
   assign req_beat.token_code     = req_token_code;
   assign req_beat.priority_level = req_priority_level;
   assign req_beat.assoc_mode     = req_assoc_mode;
   assign req_beat.node_index     = req_node_index;

   // Capacity and range checks.
   assign rule_next_w = {1'b0, rule_count_ff} + (IDX_W + 1)'(1);
   assign node_next_w = {1'b0, node_count_ff} + (IDX_W + 1)'(1);
   assign edge_next_w = {1'b0, edge_count_ff} + (IDX_W + 1)'(1);
   assign rule_full   = rule_next_w >= (IDX_W + 1)'(rtb_pkg::RULE_SLOTS);
   assign grow_full   = (node_next_w >= (IDX_W + 1)'(rtb_pkg::NODE_SLOTS)) ||
                        (edge_next_w >= (IDX_W + 1)'(rtb_pkg::EDGE_SLOTS));
   assign rule_oor    = {1'b0, req_rule_index} >= (IDX_W + 1)'(rtb_pkg::RULE_SLOTS);
   assign node_oor    = {1'b0, req_node_index} >= (IDX_W + 1)'(rtb_pkg::NODE_SLOTS);
   assign token_hit   = edge_rdata_ff.tok == req_ff.token_code[rtb_pkg::TOKEN_BITS-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtb_pkg::S_CLEAR: begin
            if (clr_cnt_ff == '1) begin
               state_in = rtb_pkg::S_IDLE;
            end
         end
         rtb_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op_code)
                  rtb_pkg::OP_ADD_TOKEN: begin
                     state_in = rule_oor ? rtb_pkg::S_EMIT : rtb_pkg::S_NODE_RD;
                  end
                  rtb_pkg::OP_END_RULE: begin
                     state_in = node_oor ? rtb_pkg::S_EMIT : rtb_pkg::S_MARK_CHK;
                  end
                  default: begin
                     state_in = rtb_pkg::S_EMIT;
                  end
               endcase
            end
         end
         rtb_pkg::S_NODE_RD: begin
            state_in = rtb_pkg::S_NODE_CHK;
         end
         rtb_pkg::S_NODE_CHK: begin
            state_in = (tab_rdata_ff.ptr == '0) ? rtb_pkg::S_ALLOC : rtb_pkg::S_EDGE_CHK;
         end
         rtb_pkg::S_EDGE_CHK: begin
            if (token_hit) begin
               state_in = rtb_pkg::S_EMIT;
            end else if (edge_rdata_ff.next == '0) begin
               state_in = rtb_pkg::S_ALLOC;
            end
         end
         rtb_pkg::S_ALLOC: begin
            state_in = grow_full ? rtb_pkg::S_EMIT : rtb_pkg::S_ALLOC_RULE;
         end
         rtb_pkg::S_ALLOC_RULE: begin
            state_in = rtb_pkg::S_EMIT;
         end
         rtb_pkg::S_MARK_CHK: begin
            state_in = rtb_pkg::S_EMIT;
         end
         rtb_pkg::S_EMIT: begin
            if (slot_free) begin
               state_in = rtb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rtb_pkg::S_IDLE;
         end
      endcase
   end

   // Memory accesses, counter updates and the result of each state.
   // One item is in flight at a time and every write lands before the next
   // item issues its first read, so no forwarding path is needed.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      rule_count_in = rule_count_ff;
      req_in        = req_ff;
      rule_word_in  = rule_word_ff;
      node_word_in  = node_word_ff;
      res_in        = res_ff;
      tab_raddr     = '0;
      tab_we        = 1'b0;
      tab_waddr     = '0;
      tab_wdata     = '0;
      edge_raddr    = '0;
      edge_we       = 1'b0;
      edge_waddr    = '0;
      edge_wdata    = '0;
      rsp_push      = 1'b0;
      case (state_ff)
         rtb_pkg::S_CLEAR: begin
            // Clearing pass: zero one table word per cycle.
            tab_we     = 1'b1;
            tab_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + TAB_AW'(1);
         end
         rtb_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_beat;
               res_in = '{result_index: '0, matched_existing: 1'b0,
                          status: rtb_pkg::ST_OK};
               case (req_op_code)
                  rtb_pkg::OP_NEW_RULE: begin
                     if (rule_full) begin
                        res_in.status = rtb_pkg::ST_FULL;
                     end else begin
                        tab_we         = 1'b1;
                        tab_waddr      = {rtb_pkg::REGION_RULE, rule_next_w[IDX_W-1:0]};
                        tab_wdata.tok  = req_token_code[rtb_pkg::TOKEN_BITS-1:0];
                        tab_wdata.ptr  = rtb_pkg::ROOT_NODE;
                        rule_count_in  = rule_next_w[IDX_W-1:0];
                        res_in.result_index = rule_next_w[IDX_W-1:0];
                     end
                  end
                  rtb_pkg::OP_ADD_TOKEN: begin
                     if (rule_oor) begin
                        res_in.status = rtb_pkg::ST_FULL;
                     end else begin
                        tab_raddr = {rtb_pkg::REGION_RULE, req_rule_index};
                     end
                  end
                  rtb_pkg::OP_END_RULE: begin
                     if (node_oor) begin
                        res_in.status = rtb_pkg::ST_FULL;
                     end else begin
                        tab_raddr = {rtb_pkg::REGION_NODE, req_node_index};
                     end
                  end
                  default: begin
                     res_in.status = rtb_pkg::ST_OK;
                  end
               endcase
            end
         end
         rtb_pkg::S_NODE_RD: begin
            // Rule word is back: fetch the node under its cursor.
            rule_word_in = tab_rdata_ff;
            tab_raddr    = {rtb_pkg::REGION_NODE, tab_rdata_ff.ptr};
         end
         rtb_pkg::S_NODE_CHK: begin
            // Node word is back: start the edge walk at its first edge.
            node_word_in = tab_rdata_ff;
            edge_raddr   = tab_rdata_ff.ptr;
         end
         rtb_pkg::S_EDGE_CHK: begin
            if (token_hit) begin
               // Follow the matching edge.
               tab_we        = 1'b1;
               tab_waddr     = {rtb_pkg::REGION_RULE, req_ff.rule_index};
               tab_wdata     = rule_word_ff;
               tab_wdata.ptr = edge_rdata_ff.target;
               res_in = '{result_index: edge_rdata_ff.target, matched_existing: 1'b1,
                          status: rtb_pkg::ST_OK};
            end else begin
               edge_raddr = edge_rdata_ff.next;
            end
         end
         rtb_pkg::S_ALLOC: begin
            if (grow_full) begin
               res_in.status = rtb_pkg::ST_FULL;
            end else begin
               // New edge at the head of the node's list.
               edge_we           = 1'b1;
               edge_waddr        = edge_next_w[IDX_W-1:0];
               edge_wdata.next   = node_word_ff.ptr;
               edge_wdata.tok    = req_ff.token_code[rtb_pkg::TOKEN_BITS-1:0];
               edge_wdata.target = node_next_w[IDX_W-1:0];
               edge_wdata.prio   = req_ff.priority_level;
               edge_wdata.assoc  = req_ff.assoc_mode;
               tab_we            = 1'b1;
               tab_waddr         = {rtb_pkg::REGION_NODE, rule_word_ff.ptr};
               tab_wdata         = node_word_ff;
               tab_wdata.ptr     = edge_next_w[IDX_W-1:0];
               node_count_in     = node_next_w[IDX_W-1:0];
               edge_count_in     = edge_next_w[IDX_W-1:0];
            end
         end
         rtb_pkg::S_ALLOC_RULE: begin
            // Move the cursor to the node just allocated.
            tab_we        = 1'b1;
            tab_waddr     = {rtb_pkg::REGION_RULE, req_ff.rule_index};
            tab_wdata     = rule_word_ff;
            tab_wdata.ptr = node_count_ff;
            res_in.result_index = node_count_ff;
         end
         rtb_pkg::S_MARK_CHK: begin
            if (tab_rdata_ff.mark != '0) begin
               res_in.status = rtb_pkg::ST_MARKED;
            end else begin
               tab_we         = 1'b1;
               tab_waddr      = {rtb_pkg::REGION_NODE, req_ff.node_index};
               tab_wdata      = tab_rdata_ff;
               tab_wdata.mark = req_ff.rule_index;
            end
         end
         rtb_pkg::S_EMIT: begin
            rsp_push = slot_free;
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtb_pkg::S_CLEAR;
         clr_cnt_ff    <= '0;
         node_count_ff <= rtb_pkg::ROOT_NODE;
         edge_count_ff <= '0;
         rule_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         rule_count_ff <= rule_count_in;
      end
   end

   // Working registers of the item in flight.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rule_word_ff <= rule_word_in;
      node_word_ff <= node_word_in;
      res_ff       <= res_in;
   end

   // Node/rule table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rdata_ff <= tab_mem[tab_raddr];
   end

   // Edge table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rdata_ff <= edge_mem[edge_raddr];
   end

   // Result register toward the rsp_ channel.
   rtb_rsp_slot u_rsp_slot (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (res_ff),
      .free      (slot_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_result_index     = rsp_data.result_index;
   assign rsp_matched_existing = rsp_data.matched_existing;
   assign rsp_status           = rsp_data.status;

`ifndef SYNTH
   // Nodes and edges are always allocated in pairs past the root.
   a_count_pair: assert property (@(posedge clock) disable iff (reset)
      node_count_ff == edge_count_ff + IDX_W'(1))
      else $error("node and edge counts out of step");

   // A rule cursor never points past the allocated nodes.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtb_pkg::S_NODE_RD) |-> (tab_rdata_ff.ptr <= node_count_ff))
      else $error("rule cursor beyond allocated nodes");

   // An edge link only reaches edges that were written.
   a_link_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtb_pkg::S_EDGE_CHK) |-> (edge_rdata_ff.next <= edge_count_ff))
      else $error("edge link beyond allocated edges");

   // A new edge is written exactly at the slot the edge count moves to.
   a_edge_slot: assert property (@(posedge clock) disable iff (reset)
      edge_we |=> (edge_count_ff == $past(edge_waddr)) && (edge_count_ff != '0))
      else $error("edge written outside its allocated slot");
`endif

endmodule

### hdl/rtb_rsp_slot.sv
// One-beat result register that parts the core from the result channel.
module rtb_rsp_slot (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtb_pkg::rsp_type push_data,
   output logic             free,
   output logic             out_valid,
   input  logic             out_ready,
   output rtb_pkg::rsp_type out_data
);

   logic             valid_ff;
   logic             valid_in;
   rtb_pkg::rsp_type data_ff;

   // The slot can take a beat when it is empty or its beat leaves now.
   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload needs no reset; it is loaded with every beat.
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule
